// ===== hw/rtl/q2e_pkg.sv =====
// q2e_pkg: constants, types and CORDIC angle table for quaternion_to_euler
// no dependencies
package q2e_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NSTAGES = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam int OPW = 40;   // cordic operand width, inputs below 2^36 plus growth
    localparam int ACCW = 32;  // angle accumulator width
    localparam int SQW = 58;   // width of 2^56 - a^2
    localparam int SQN = 29;   // root bits
    localparam logic signed [ACCW-1:0] ANG90 = ACCW'(9000 * 65536);
    localparam logic signed [29:0] ONE_Q28 = 30'sd268435456;

    typedef logic signed [OPW-1:0] op_t;
    typedef logic signed [ACCW-1:0] acc_t;

    typedef struct packed {
        op_t  x;
        op_t  y;
        acc_t acc;
        logic fixed;        // result already known
        logic signed [15:0] fixed_val;
    } cst_t;

    function automatic acc_t atan_tab(input int i);
        case (i)
            0: atan_tab = 294912000; 1: atan_tab = 174096719; 2: atan_tab = 91987925;
            3: atan_tab = 46694507;  4: atan_tab = 23437865;  5: atan_tab = 11730358;
            6: atan_tab = 5866610;   7: atan_tab = 2933484;   8: atan_tab = 1466764;
            9: atan_tab = 733385;    10: atan_tab = 366693;   11: atan_tab = 183346;
            12: atan_tab = 91673;    13: atan_tab = 45837;    14: atan_tab = 22918;
            15: atan_tab = 11459;    16: atan_tab = 5730;     17: atan_tab = 2865;
            18: atan_tab = 1432;     19: atan_tab = 716;      20: atan_tab = 358;
            21: atan_tab = 179;      22: atan_tab = 90;       default: atan_tab = 45;
        endcase
    endfunction

endpackage

// ===== hw/rtl/q2e_if.sv =====
// q2e_if: valid/ready channel carrying a generic payload
// depends on nothing
interface q2e_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/q2e_cordic_stage.sv =====
// q2e_cordic_stage: one combinational vectoring CORDIC micro-rotation
// depends on q2e_pkg
module q2e_cordic_stage
    import q2e_pkg::*;
(
    input  cst_t        din,
    input  logic [4:0]  shift,
    output cst_t        dout
);
    op_t xs;
    op_t ys;
    always_comb
    begin
        xs = din.x >>> shift;
        ys = din.y >>> shift;
        dout = din;
        if (!din.y[OPW-1])
        begin
            dout.x = din.x + ys;
            dout.y = din.y - xs;
            dout.acc = din.acc + atan_tab(int'(shift));
        end
        else
        begin
            dout.x = din.x - ys;
            dout.y = din.y + xs;
            dout.acc = din.acc - atan_tab(int'(shift));
        end
    end
endmodule

// ===== hw/rtl/quaternion_to_euler.sv =====
// quaternion_to_euler: quaternion to euler angles, fully pipelined
// depends on q2e_pkg, q2e_if, q2e_cordic_stage
//
// usage:
//   in  channel (q2e_if sink): data = {quat_z, quat_y, quat_x, quat_w}, each 16 bit Q1.14
//   out channel (q2e_if source): data = {asin_saturated, angle_z, angle_y, angle_x}
//   one transaction accepted per cycle unless stalled; every stage carries a valid bit
//   stages: product, sum/clamp and square stages, 29 root stages, a setup stage,
//   one stage per cordic iteration and an output stage
//   throughput one quaternion per cycle unless stalled
//   the whole pipe advances only when the output register is empty or taken,
//   so a stalled receiver freezes every stage and nothing is lost or repeated
//   reset clears all valid bits; payload registers are not reset
//   the y angle argument is clamped to +-1 and asin_saturated is raised then
//   atan2(0,0) gives 0
module quaternion_to_euler
    import q2e_pkg::*;
(
    input logic clk,
    input logic rst_n,
    q2e_if.sink   in_ch,
    q2e_if.source out_ch
);
    localparam int DEPTH = 3 + SQN + 1 + NSTAGES;

    logic adv;
    logic [DEPTH-1:0] v_reg;
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // stage 1: products
    logic signed [15:0] w, x, y, z;
    assign w = in_ch.data[15:0];
    assign x = in_ch.data[31:16];
    assign y = in_ch.data[47:32];
    assign z = in_ch.data[63:48];
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg, yz_reg, xw_reg, xy_reg, zw_reg,
        xz_reg, yw_reg;
    // stage 2: sums
    op_t ax_y_reg, ax_x_reg, az_y_reg, az_x_reg;
    logic signed [29:0] a_reg;
    logic sat_reg;
    logic signed [35:0] a_next;
    logic signed [29:0] ac_next;
    logic sat_next;
    always_comb
    begin
        a_next = 36'sd2 * (36'(yw_reg) - 36'(xz_reg));
        sat_next = 1'b0;
        ac_next = a_next[29:0];
        if (a_next > 36'(ONE_Q28))
        begin
            ac_next = ONE_Q28; sat_next = 1'b1;
        end
        else if (a_next < -36'(ONE_Q28))
        begin
            ac_next = -ONE_Q28; sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= w * w; xx_reg <= x * x; yy_reg <= y * y; zz_reg <= z * z;
            yz_reg <= y * z; xw_reg <= x * w; xy_reg <= x * y; zw_reg <= z * w;
            xz_reg <= x * z; yw_reg <= y * w;
            ax_y_reg <= OPW'(36'sd2 * (36'(yz_reg) + 36'(xw_reg)));
            ax_x_reg <= OPW'(-36'(xx_reg) - 36'(yy_reg) + 36'(zz_reg) + 36'(ww_reg));
            az_y_reg <= OPW'(36'sd2 * (36'(xy_reg) + 36'(zw_reg)));
            az_x_reg <= OPW'(36'(xx_reg) - 36'(yy_reg) - 36'(zz_reg) + 36'(ww_reg));
            a_reg <= ac_next;
            sat_reg <= sat_next;
        end
    end

    // stage 3: square; then square root, one result bit per stage
    logic [SQW-1:0] rv_reg [SQN+1];
    logic [SQN-1:0] rr_reg [SQN+1];
    logic signed [29:0] ra_reg [SQN+1];
    logic rs_reg [SQN+1];
    op_t rax_y_reg [SQN+1], rax_x_reg [SQN+1], raz_y_reg [SQN+1], raz_x_reg [SQN+1];
    logic signed [59:0] asq;
    assign asq = a_reg * a_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rv_reg[0] <= SQW'(60'sd1 <<< 56) - SQW'(asq);
            rr_reg[0] <= '0;
            ra_reg[0] <= a_reg;
            rs_reg[0] <= sat_reg;
            rax_y_reg[0] <= ax_y_reg; rax_x_reg[0] <= ax_x_reg;
            raz_y_reg[0] <= az_y_reg; raz_x_reg[0] <= az_x_reg;
        end
    end
    for (genvar k = 0; k < SQN; k++)
    begin : g_sqrt
        logic [SQW:0] trial;
        logic [SQW-1:0] rem;
        logic [SQN-1:0] r;
        always_comb
        begin
            // remainder and root in restoring form, most significant bit pair first
            trial = (SQW+1)'(rv_reg[k] >> (2 * (SQN - 1 - k)))
                - (SQW+1)'({rr_reg[k], 2'b01});
            rem = rv_reg[k];
            r = rr_reg[k] << 1;
            if (!trial[SQW])
            begin
                rem = rv_reg[k] - (SQW'({rr_reg[k], 2'b01}) << (2 * (SQN - 1 - k)));
                r = r | SQN'(1);
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rv_reg[k+1] <= rem; rr_reg[k+1] <= r;
                ra_reg[k+1] <= ra_reg[k]; rs_reg[k+1] <= rs_reg[k];
                rax_y_reg[k+1] <= rax_y_reg[k]; rax_x_reg[k+1] <= rax_x_reg[k];
                raz_y_reg[k+1] <= raz_y_reg[k]; raz_x_reg[k+1] <= raz_x_reg[k];
            end
        end
    end

    // cordic setup
    function automatic cst_t setup(input op_t yy, input op_t xx);
        cst_t s;
        s.x = xx; s.y = yy; s.acc = '0; s.fixed = 1'b0; s.fixed_val = '0;
        if (xx == '0)
        begin
            s.fixed = 1'b1;
            s.fixed_val = (yy > 0) ? 16'sd9000 : ((yy < 0) ? -16'sd9000 : 16'sd0);
        end
        else if (xx < 0)
        begin
            if (!yy[OPW-1])
            begin
                s.x = yy; s.y = -xx; s.acc = ANG90;
            end
            else
            begin
                s.x = -yy; s.y = xx; s.acc = -ANG90;
            end
        end
        return s;
    endfunction

    cst_t cx_reg [NSTAGES+1], cy_reg [NSTAGES+1], cz_reg [NSTAGES+1];
    logic sat_p_reg [NSTAGES+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= setup(rax_y_reg[SQN], rax_x_reg[SQN]);
            cz_reg[0] <= setup(raz_y_reg[SQN], raz_x_reg[SQN]);
            cy_reg[0] <= setup(OPW'(ra_reg[SQN]), OPW'({1'b0, rr_reg[SQN]}));
            sat_p_reg[0] <= rs_reg[SQN];
        end
    end
    for (genvar i = 0; i < NSTAGES; i++)
    begin : g_cordic
        cst_t nx, ny, nz;
        q2e_cordic_stage u_x (.din(cx_reg[i]), .shift(5'(i)), .dout(nx));
        q2e_cordic_stage u_y (.din(cy_reg[i]), .shift(5'(i)), .dout(ny));
        q2e_cordic_stage u_z (.din(cz_reg[i]), .shift(5'(i)), .dout(nz));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[i+1] <= nx; cy_reg[i+1] <= ny; cz_reg[i+1] <= nz;
                sat_p_reg[i+1] <= sat_p_reg[i];
            end
        end
    end

    function automatic logic signed [15:0] fin(input cst_t s, input int lim);
        logic signed [ACCW-1:0] r;
        if (s.fixed)
            return s.fixed_val;
        r = (s.acc + ACCW'(32768)) >>> 16;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    logic signed [15:0] ay_fin;
    assign ay_fin = fin(cy_reg[NSTAGES], 9000);

    logic [47:0] out_data_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {sat_p_reg[NSTAGES], fin(cz_reg[NSTAGES], 18000),
                ay_fin[14:0], fin(cx_reg[NSTAGES], 18000)};
        end
    end
    assign out_ch.data = out_data_reg;

    logic out_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_ch.valid};
            out_v_reg <= v_reg[DEPTH-1];
        end
    end
    assign out_ch.valid = out_v_reg;
endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for quaternion_to_euler, random and directed quaternions
// depends on q2e_pkg, q2e_if and the quaternion_to_euler rtl
module tb
    import q2e_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [14:0] ay;
        logic signed [15:0] az;
        logic sat;
    } euler_t;

    logic clk;
    logic rst_n;

    q2e_if #(.W(64)) in_ch ();
    q2e_if #(.W(48)) out_ch ();

    quaternion_to_euler u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    logic [63:0] quat_q[$];
    euler_t angles_q[$];
    int mismatches = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit gaps_on = 1;
    bit hold_send = 0;
    bit in_acc = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic void add_quat(logic [63:0] q);
        quat_q.insert(quat_q.size(), q);
    endfunction

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint lim(longint v, longint m);
        if (v > m)
            return m;
        if (v < -m)
            return -m;
        return v;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint acc;
        longint t;
        longint xs;
        longint ys;
        longint tab[24];
        tab = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                5866610, 2933484, 1466764, 733385, 366693, 183346,
                91673, 45837, 22918, 11459, 5730, 2865,
                1432, 716, 358, 179, 90, 45};
        acc = 0;
        if (x == 0)
            return (y > 0) ? 9000 : ((y < 0) ? -9000 : 0);
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; acc = 9000 * 65536;
            end
            else
            begin
                t = x; x = -y; y = t; acc = -9000 * 65536;
            end
        end
        for (int i = 0; i < NSTAGES; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; acc += tab[i];
            end
            else
            begin
                x -= ys; y += xs; acc -= tab[i];
            end
        end
        return lim(floor_shr(acc + 32768, 16), 18000);
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t quat_to_euler(logic [63:0] q);
        longint w;
        longint x;
        longint y;
        longint z;
        longint a;
        longint one;
        euler_t e;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        one = 64'sd1 <<< 28;
        e.ax = 16'(vec_angle(2 * (y * z + x * w), -x * x - y * y + z * z + w * w));
        e.az = 16'(vec_angle(2 * (x * y + z * w), x * x - y * y - z * z + w * w));
        a = -2 * (x * z - y * w);
        e.sat = 1'b0;
        if (a > one)
        begin
            a = one; e.sat = 1'b1;
        end
        else if (a < -one)
        begin
            a = -one; e.sat = 1'b1;
        end
        e.ay = 15'(lim(vec_angle(a, int_root(longint'(one * one - a * a))), 9000));
        return e;
    endfunction

    function automatic logic [15:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 32768)) - 16384);
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($signed($urandom_range(0, 23170)) - 11585);
        endcase
    endfunction

    // input transaction taken at the last rising edge
    always @(posedge clk)
        in_acc <= in_ch.valid && in_ch.ready;

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            in_gap <= 0;
        end
        else if (in_ch.valid && !in_acc)
        begin
        end
        else if (in_gap > 0)
        begin
            in_gap <= in_gap - 1;
            in_ch.valid <= 1'b0;
        end
        else if (quat_q.size() > 0 && !hold_send)
        begin
            in_ch.valid <= 1'b1;
            in_ch.data <= quat_q.pop_front();
            if (gaps_on && $urandom_range(0, 9) == 0)
                in_gap <= $urandom_range(1, 15);
        end
        else
            in_ch.valid <= 1'b0;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end
        else if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 11) == 0)
        begin
            out_gap <= $urandom_range(1, 15);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // predict on input transaction, check on output transaction
    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && in_ch.valid && in_ch.ready)
            angles_q.insert(angles_q.size(), quat_to_euler(in_ch.data));
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (angles_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_ch.data);
            end
            else
            begin
                e = angles_q.pop_front();
                if (out_ch.data[15:0] !== e.ax || out_ch.data[30:16] !== e.ay
                    || out_ch.data[46:31] !== e.az || out_ch.data[47] !== e.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                                 e.ax, e.ay, e.az, e.sat,
                                 $signed(out_ch.data[15:0]), $signed(out_ch.data[30:16]),
                                 $signed(out_ch.data[46:31]), out_ch.data[47]);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("** quaternion_to_euler: FAILED **");
        $finish;
    end

    initial
    begin
        logic [15:0] ext[6];
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        ext = '{16'h4000, 16'hc000, 16'h0000, 16'h7fff, 16'h8000, 16'h2d41};
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: zero, identity, axes, saturation, extremes
        add_quat(64'h0);
        add_quat({16'h0, 16'h0, 16'h0, 16'h4000});
        add_quat({16'h0, 16'h0, 16'h0, 16'hc000});
        add_quat({16'h0, 16'h0, 16'h4000, 16'h0});
        add_quat({16'h0, 16'h4000, 16'h0, 16'h0});
        add_quat({16'h4000, 16'h0, 16'h0, 16'h0});
        add_quat({16'h0, 16'h2d41, 16'h0, 16'h2d41});
        add_quat({16'h0, 16'hd2bf, 16'h0, 16'h2d41});
        add_quat({16'h4000, 16'h4000, 16'h4000, 16'h4000});
        add_quat({16'hc000, 16'h4000, 16'hc000, 16'h4000});
        add_quat({4{16'h7fff}});
        add_quat({4{16'h8000}});
        add_quat({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        add_quat({16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
        add_quat({16'h0001, 16'hffff, 16'h0001, 16'h0000});
        for (int i = 0; i < 10; i++)
            add_quat({ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                      ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)]});
        for (int i = 0; i < 1600; i++)
        begin
            w = rand_part();
            x = rand_part();
            y = rand_part();
            z = rand_part();
            add_quat({z, y, x, w});
            if (i == 700)
            begin
                wait (quat_q.size() == 0);
                hold_send = 1'b1;
                wait (!in_ch.valid && angles_q.size() == 0);
                @(negedge clk);
                hold_send = 1'b0;
            end
            if (i == 1300)
            begin
                wait (quat_q.size() == 0);
                gaps_on = 1'b0;
            end
        end
        wait (quat_q.size() == 0 && !in_ch.valid);
        @(posedge clk);
        wait (angles_q.size() == 0);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && angles_q.size() == 0)
            $display("** quaternion_to_euler: PASSED **");
        else
            $display("** quaternion_to_euler: FAILED **");
        $finish;
    end
endmodule
